// File: rtl/tpcl_pkg.sv
package tpcl_pkg;

    localparam int BUF_DEPTH_DEFAULT = 64;

    localparam int TICK_W = 16;
    localparam int WRAP_W = 8;
    localparam int REC_W  = TICK_W + WRAP_W;
    localparam int BYTE_W = 8;

    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
    localparam logic [WRAP_W-1:0] WRAP_MAX      = 8'hFF;
    localparam logic [BYTE_W-1:0] CHECKSUM_BASE = 8'd64;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_EDGE  = 2'd1,
        MODE_SENSE = 2'd2,
        MODE_SEND  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BYTE_LO   = 2'd0,
        BYTE_HI   = 2'd1,
        BYTE_WRAP = 2'd2,
        BYTE_SUM  = 2'd3
    } t_byte_sel;

    typedef struct packed {
        logic send;
        logic sense;
        logic ovf;
    } t_status;

endpackage

// File: rtl/tpcl_ram.sv
module tpcl_ram #(
    parameter int WIDTH = tpcl_pkg::REC_W,
    parameter int DEPTH = tpcl_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/tape_pulse_capture_logger_unit.sv
// Pulse-width capture logger. One input transfer is taken per cycle while
// o_in_ready is high: timer ticks, edges, sense samples and a send on an
// empty buffer each give one status result with no byte, and a send request
// on a non-empty buffer gives four byte results (counter low, counter high,
// wrap count, checksum), one per cycle while the output is ready; a send holds
// the output until its checksum byte transfers, and the input stalls once s1
// behind it is full. A result is registered in s1, where the registered read
// of the record buffer RAM lands, then in the output register, and waits in
// s1 while the output is busy. The buffer needs no clearing pass after reset.
module tape_pulse_capture_logger_unit #(
    parameter int BUF_DEPTH = tpcl_pkg::BUF_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic        i_sense_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_byte_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic        o_sense_out,
    output logic        o_overflow_flag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int PW = $clog2(BUF_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(BUF_DEPTH - 1);

    logic [tpcl_pkg::TICK_W-1:0] r_min;
    logic [tpcl_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [tpcl_pkg::WRAP_W-1:0] r_wrap, n_wrap;
    logic [PW-1:0]               r_rd_pos, n_rd_pos;
    logic [PW-1:0]               r_wr_pos, n_wr_pos;
    logic                        r_empty, n_empty;
    logic                        r_ovf, n_ovf;
    logic                        r_sense_state, n_sense_state;
    logic                        r_sense_drive, n_sense_drive;

    logic                        offer;
    logic [tpcl_pkg::TICK_W-1:0] offer_ticks;
    logic [tpcl_pkg::WRAP_W-1:0] offer_wraps;
    logic                        wr_en;
    logic [PW-1:0]               wr_addr;
    logic                        rd_en;
    logic                        send;
    logic [tpcl_pkg::REC_W-1:0]  rd_data;

    logic                        r_s1_valid;
    tpcl_pkg::t_status           r_s1;

    logic                        r_out_valid;
    tpcl_pkg::t_status           r_out;
    tpcl_pkg::t_byte_sel         r_out_sel;
    logic [tpcl_pkg::REC_W-1:0]  r_out_rec;
    logic [tpcl_pkg::BYTE_W-1:0] r_out_sum;

    logic in_xfer, out_xfer, out_last, out_free, s1_adv;

    assign o_cfg_ready = 1'b1;

    assign out_last = !r_out.send || (r_out_sel == tpcl_pkg::BYTE_SUM);
    assign out_xfer = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || (out_xfer && out_last);
    assign s1_adv   = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_xfer  = i_in_valid && o_in_ready;

    // state update for one transfer
    always_comb begin
        n_tick        = r_tick;
        n_wrap        = r_wrap;
        n_rd_pos      = r_rd_pos;
        n_wr_pos      = r_wr_pos;
        n_empty       = r_empty;
        n_ovf         = r_ovf;
        n_sense_state = r_sense_state;
        n_sense_drive = r_sense_drive;
        offer         = 1'b0;
        offer_ticks   = r_tick;
        offer_wraps   = r_wrap;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_en         = 1'b0;
        send          = 1'b0;
        if (in_xfer) begin
            unique case (tpcl_pkg::t_mode'(i_mode))
                tpcl_pkg::MODE_TICK: begin
                    n_tick = r_tick + 16'd1;
                    if (n_tick == '0) begin
                        if (r_wrap != tpcl_pkg::WRAP_MAX) begin
                            n_wrap = r_wrap + 8'd1;
                        end else begin
                            offer       = 1'b1;
                            offer_ticks = tpcl_pkg::TICK_MAX;
                            offer_wraps = tpcl_pkg::WRAP_MAX;
                            n_wrap      = '0;
                        end
                    end
                end
                tpcl_pkg::MODE_EDGE: begin
                    offer  = 1'b1;
                    n_tick = '0;
                    n_wrap = '0;
                end
                tpcl_pkg::MODE_SENSE: begin
                    if (i_sense_level != r_sense_state) begin
                        n_sense_state = i_sense_level;
                        n_sense_drive = i_sense_level;
                        if (i_sense_level) begin
                            n_ovf = 1'b0;
                        end
                    end
                end
                tpcl_pkg::MODE_SEND: begin
                    if (!r_empty) begin
                        rd_en = 1'b1;
                        send  = 1'b1;
                        if (r_rd_pos >= r_wr_pos) begin
                            n_empty  = 1'b1;
                            n_rd_pos = '0;
                            n_wr_pos = '0;
                        end else begin
                            n_rd_pos = r_rd_pos + PW'(1);
                        end
                    end
                end
                default: ;
            endcase

            if (offer && !r_sense_state && !r_ovf
                    && !(offer_wraps == '0 && offer_ticks < r_min)) begin
                if (!r_empty && r_wr_pos == LAST_SLOT) begin
                    n_ovf = 1'b1;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = r_empty ? '0 : r_wr_pos + PW'(1);
                    n_wr_pos = wr_addr;
                    n_empty  = 1'b0;
                    if (r_empty) begin
                        n_rd_pos = '0;
                    end
                end
            end

            n_sense_drive = n_sense_drive | n_ovf;
        end
    end

    tpcl_ram #(
        .WIDTH (tpcl_pkg::REC_W),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({offer_wraps, offer_ticks}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_pos),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min         <= '0;
            r_tick        <= '0;
            r_wrap        <= '0;
            r_rd_pos      <= '0;
            r_wr_pos      <= '0;
            r_empty       <= 1'b1;
            r_ovf         <= 1'b0;
            r_sense_state <= 1'b0;
            r_sense_drive <= 1'b1;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_sel     <= tpcl_pkg::BYTE_LO;
        end else begin
            if (i_cfg_valid) begin
                r_min <= i_cfg_data;
            end
            r_tick        <= n_tick;
            r_wrap        <= n_wrap;
            r_rd_pos      <= n_rd_pos;
            r_wr_pos      <= n_wr_pos;
            r_empty       <= n_empty;
            r_ovf         <= n_ovf;
            r_sense_state <= n_sense_state;
            r_sense_drive <= n_sense_drive;

            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_out_sel   <= tpcl_pkg::BYTE_LO;
            end else if (out_xfer) begin
                if (out_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_out_sel <= tpcl_pkg::t_byte_sel'(r_out_sel + 2'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= '{send: send, sense: n_sense_drive, ovf: n_ovf};
        end
        if (s1_adv) begin
            r_out     <= r_s1;
            r_out_rec <= rd_data;
            r_out_sum <= tpcl_pkg::CHECKSUM_BASE + rd_data[7:0] + rd_data[15:8]
                         + rd_data[23:16];
        end
    end

    always_comb begin
        o_tx_byte = '0;
        if (r_out.send) begin
            case (r_out_sel)
                tpcl_pkg::BYTE_LO:   o_tx_byte = r_out_rec[7:0];
                tpcl_pkg::BYTE_HI:   o_tx_byte = r_out_rec[15:8];
                tpcl_pkg::BYTE_WRAP: o_tx_byte = r_out_rec[23:16];
                tpcl_pkg::BYTE_SUM:  o_tx_byte = r_out_sum;
                default:             o_tx_byte = '0;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_out.send;
    assign o_last_byte     = out_last;
    assign o_sense_out     = r_out.sense;
    assign o_overflow_flag = r_out.ovf;

`ifndef SYNTHESIS
    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_last_byte && o_tx_byte == '0)
        else $error("status result carries a byte");

    a_empty_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> r_rd_pos == '0 && r_wr_pos == '0)
        else $error("empty buffer with nonzero positions");

    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_empty |-> r_rd_pos <= r_wr_pos)
        else $error("read position past write position");

    a_ovf_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_sense_drive)
        else $error("overflow without sense forced high");
`endif

endmodule
